/* src/vuss_pkg.sv */
// Package of shared types, constants and helper functions for the UV seam splitter.
`timescale 1ns / 1ps
`default_nettype none

package vuss_pkg;

  // Field widths fixed by the corner and result formats.
  localparam int VTX_W = 16;
  localparam int UV_W  = 32;
  localparam int CNT_W = 17;

  // The visited bitmap is kept as rows of 64 bits, one row per memory word.
  localparam int MAP_DEPTH = 1 << VTX_W;
  localparam int ROW_BITS  = 64;
  localparam int ROW_SEL_W = $clog2(ROW_BITS);
  localparam int ROWS      = MAP_DEPTH / ROW_BITS;
  localparam int ROW_AW    = $clog2(ROWS);

  // Default size of the vertex store on the host side.
  localparam int MAX_VERTICES_DEF = 65536;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd1;

  // One triangle corner as it arrives.
  typedef struct packed {
    logic [VTX_W-1:0] corner_vertex;
    logic [UV_W-1:0]  corner_u;
    logic [UV_W-1:0]  corner_v;
  } in_item_t;

  // One result as it leaves.
  typedef struct packed {
    logic [VTX_W-1:0] remapped_vertex;
    logic             duplicated;
    logic [VTX_W-1:0] copy_source;
    logic             uv_write;
    logic             overflow;
  } out_item_t;

  // Classification of the corner UV pair made at the front.
  typedef struct packed {
    logic u_nan;
    logic u_zero;
    logic v_nan;
    logic v_zero;
  } fp_class_t;

  // A queued corner with its classification.
  typedef struct packed {
    in_item_t  item;
    fp_class_t cls;
  } q_entry_t;

  // Head of the queue as the back end sees it.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  // True for any NaN pattern, quiet or signaling.
  function automatic logic is_nan32(input logic [UV_W-1:0] x);
    is_nan32 = (x[UV_W-2:0] > 31'h7F80_0000);
  endfunction

  // True for plus or minus zero.
  function automatic logic is_zero32(input logic [UV_W-1:0] x);
    is_zero32 = (x[UV_W-2:0] == '0);
  endfunction

endpackage

`default_nettype wire

/* src/vertex_uv_seam_splitter.sv */
// Top level of the UV seam splitter: input queue front end and lookup back end.
`timescale 1ns / 1ps
`default_nettype none

// Splits vertices on UV seams, one triangle corner per transfer. In the back end the
// idle state pops a corner and does the registered read of the visited-bitmap row
// and the stored UV; the execute state, held while the result side stalls, does the
// compare and the update write, both on single-port memories. A two-entry queue lets
// corners be taken while the back end works. After reset the back end clears the
// visited bitmap, one 64-bit row per cycle over all 1024 rows; the queue takes two
// corners meanwhile and then stalls. Configuration writes are taken at any time.
module vertex_uv_seam_splitter #(
  parameter int MAX_VERTICES = vuss_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [vuss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vuss_pkg::CNT_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire vuss_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output vuss_pkg::out_item_t                 out_data
);

  vuss_pkg::q_head_t q_head;
  logic              q_pop;

  // Accept and classify corners.
  vuss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // Look up, update and produce results.
  vuss_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* src/vuss_front.sv */
// Front end: accepts corners, classifies their UV pair and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module vuss_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire vuss_pkg::in_item_t in_data,
  output vuss_pkg::q_head_t       q_head,
  input  wire logic               q_pop
);

  localparam int QDEPTH = 2;

  vuss_pkg::q_entry_t entry_r [QDEPTH];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         count_r, count_nxt;
  logic               push;
  logic               pop;
  vuss_pkg::q_entry_t new_entry;

  // The queue stalls the input only when both slots are taken.
  assign in_stall = (count_r == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (count_r != 2'd0);

  // Classify the UV pair once, so the back end only compares.
  always_comb begin
    new_entry.item       = in_data;
    new_entry.cls.u_nan  = vuss_pkg::is_nan32(in_data.corner_u);
    new_entry.cls.u_zero = vuss_pkg::is_zero32(in_data.corner_u);
    new_entry.cls.v_nan  = vuss_pkg::is_nan32(in_data.corner_v);
    new_entry.cls.v_zero = vuss_pkg::is_zero32(in_data.corner_v);
  end

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_entry;
    end
  end

  assign q_head.valid = (count_r != 2'd0);
  assign q_head.entry = entry_r[rd_ptr_r];

endmodule

`default_nettype wire

/* src/vuss_back.sv */
// Back end: visited bitmap, UV store, duplicate allocation and the result register.
`timescale 1ns / 1ps
`default_nettype none

module vuss_back #(
  parameter int MAX_VERTICES = vuss_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [vuss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [vuss_pkg::CNT_W-1:0]          cfg_data,
  input  wire vuss_pkg::q_head_t                   q_head,
  output logic                                     q_pop,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output vuss_pkg::out_item_t                      out_data
);

  localparam int VTX_W     = vuss_pkg::VTX_W;
  localparam int UV_W      = vuss_pkg::UV_W;
  localparam int CNT_W     = vuss_pkg::CNT_W;
  localparam int ROW_BITS  = vuss_pkg::ROW_BITS;
  localparam int ROW_SEL_W = vuss_pkg::ROW_SEL_W;
  localparam int ROW_AW    = vuss_pkg::ROW_AW;
  localparam int ROWS      = vuss_pkg::ROWS;
  localparam int MAP_DEPTH = vuss_pkg::MAP_DEPTH;
  // Appended indexes must stay below both the store size and the index range.
  localparam int LIMIT_I   = (MAX_VERTICES < MAP_DEPTH) ? MAX_VERTICES : MAP_DEPTH;
  localparam logic [CNT_W:0] DUP_LIMIT = (CNT_W + 1)'(LIMIT_I);

  vuss_pkg::back_state_t state_r, state_nxt;
  logic [ROW_AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic                  smooth_r;
  logic [CNT_W-1:0]      vcount_r;
  logic [CNT_W-1:0]      appended_r, appended_nxt;
  vuss_pkg::q_entry_t    cur_r;
  vuss_pkg::out_item_t   out_r;
  logic                  out_valid_r, out_valid_nxt;

  logic [ROW_BITS-1:0]   vis_mem [ROWS];
  logic [2*UV_W-1:0]     uv_mem  [MAP_DEPTH];
  logic [ROW_BITS-1:0]   vis_rd_r;
  logic [2*UV_W-1:0]     uv_rd_r;

  logic                  rd_en;
  logic                  vis_we;
  logic [ROW_AW-1:0]     vis_waddr;
  logic [ROW_BITS-1:0]   vis_wdata;
  logic                  uv_we;
  logic                  fire;
  logic                  out_free;
  logic                  visited;
  logic [ROW_SEL_W-1:0]  bit_sel;
  logic [UV_W-1:0]       su, sv;
  logic                  u_eq, v_eq;
  logic                  need_dup;
  logic [CNT_W:0]        next_idx;
  logic                  ovf;
  vuss_pkg::out_item_t   res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= 1'b1;
      vcount_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        vuss_pkg::CFG_SMOOTH_MODE:  smooth_r <= cfg_data[0];
        vuss_pkg::CFG_VERTEX_COUNT: vcount_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The result register is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = (state_r == vuss_pkg::BK_EXEC) && out_free;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vuss_pkg::BK_CLEAR: begin
        if (clr_addr_r == ROW_AW'(ROWS - 1)) state_nxt = vuss_pkg::BK_IDLE;
      end
      vuss_pkg::BK_IDLE: begin
        if (q_head.valid) state_nxt = vuss_pkg::BK_EXEC;
      end
      vuss_pkg::BK_EXEC: begin
        if (out_free) state_nxt = vuss_pkg::BK_IDLE;
      end
      default: state_nxt = vuss_pkg::BK_CLEAR;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      vuss_pkg::BK_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      vuss_pkg::BK_IDLE: begin
        q_pop = q_head.valid;
        rd_en = q_head.valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= vuss_pkg::BK_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Capture the corner being worked on.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head.entry;
    end
  end

  // Compare the corner UV against the stored one and decide on a duplicate.
  always_comb begin
    bit_sel  = cur_r.item.corner_vertex[ROW_SEL_W-1:0];
    visited  = vis_rd_r[bit_sel];
    su       = uv_rd_r[UV_W-1:0];
    sv       = uv_rd_r[2*UV_W-1:UV_W];
    u_eq     = !cur_r.cls.u_nan && !vuss_pkg::is_nan32(su) &&
               ((cur_r.cls.u_zero && vuss_pkg::is_zero32(su)) || (su == cur_r.item.corner_u));
    v_eq     = !cur_r.cls.v_nan && !vuss_pkg::is_nan32(sv) &&
               ((cur_r.cls.v_zero && vuss_pkg::is_zero32(sv)) || (sv == cur_r.item.corner_v));
    need_dup = visited && (!smooth_r || !(u_eq && v_eq));
    next_idx = {1'b0, vcount_r} + {1'b0, appended_r};
    ovf      = need_dup && (next_idx >= DUP_LIMIT);

    res.remapped_vertex = cur_r.item.corner_vertex;
    res.duplicated      = 1'b0;
    res.copy_source     = '0;
    res.uv_write        = !visited;
    res.overflow        = ovf;
    if (need_dup && !ovf) begin
      res.remapped_vertex = next_idx[VTX_W-1:0];
      res.duplicated      = 1'b1;
      res.copy_source     = cur_r.item.corner_vertex;
      res.uv_write        = 1'b1;
    end
  end

  // Memory write controls: the clearing pass or the update of a first visit.
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = cur_r.item.corner_vertex[VTX_W-1:ROW_SEL_W];
    vis_wdata = vis_rd_r | (ROW_BITS'(1) << bit_sel);
    uv_we     = fire && !visited;
    if (state_r == vuss_pkg::BK_CLEAR) begin
      vis_we    = 1'b1;
      vis_waddr = clr_addr_r;
      vis_wdata = '0;
    end else if (fire && !visited) begin
      vis_we = 1'b1;
    end
  end

  // Visited bitmap, one row of bits per word.
  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    if (rd_en) begin
      vis_rd_r <= vis_mem[q_head.entry.item.corner_vertex[VTX_W-1:ROW_SEL_W]];
    end
  end

  // UV store, V in the upper half and U in the lower half.
  always_ff @(posedge clk) begin
    if (uv_we) begin
      uv_mem[cur_r.item.corner_vertex] <= {cur_r.item.corner_v, cur_r.item.corner_u};
    end
    if (rd_en) begin
      uv_rd_r <= uv_mem[q_head.entry.item.corner_vertex];
    end
  end

  // Count of appended duplicates.
  assign appended_nxt = (fire && need_dup && !ovf) ? appended_r + 1'b1 : appended_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      appended_r <= '0;
    end else begin
      appended_r <= appended_nxt;
    end
  end

  // Result register.
  assign out_valid_nxt = fire ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A finished corner always reaches the result register.
  assert property (@(posedge clk) disable iff (!rst_n) fire |=> out_valid_r)
    else $error("result lost after update");

  // The duplicate counter only ever steps by one.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (appended_r != $past(appended_r))) |->
    (appended_r == CNT_W'($past(appended_r) + 1'b1)))
    else $error("appended count jumped");

  // A duplicate and an overflow are never flagged together.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.duplicated && out_r.overflow))
    else $error("duplicate and overflow both set");

  // No corner is taken from the queue during the clearing pass.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vuss_pkg::BK_CLEAR) |-> !q_pop)
    else $error("corner popped during clearing pass");

endmodule

`default_nettype wire
